@@ sv/assert_macros.svh @@
// Assertion helpers; bodies drop out when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

@@ sv/itw_pkg.sv @@
`timescale 1ns / 1ps

package itw_pkg;

  localparam int unsigned TIMEOUT_DEF  = 30;
  localparam int unsigned MAX_CONN_DEF = 64;

  localparam int unsigned OP_W       = 2;
  localparam int unsigned CONN_W     = 6;
  localparam int unsigned EV_W       = 3;
  localparam int unsigned SLOT_OUT_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_TOUCH  = 2'd0,
    OP_REMOVE = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [EV_W-1:0] {
    EV_ARMED     = 3'd0,
    EV_REARMED   = 3'd1,
    EV_REMOVED   = 3'd2,
    EV_NOT_FOUND = 3'd3,
    EV_EXPIRED   = 3'd4,
    EV_TICK_DONE = 3'd5
  } event_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_TOUCH,
    ST_NOT_FOUND,
    ST_RM_RD,
    ST_RM_RES,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_SCAN_END
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic latch_in;
    logic touch;      // write slot, set valid, push armed/rearmed
    logic not_found;  // push not-found
    logic rd_id;      // read slot table at latched id
    logic remove;     // clear valid, push removed
    logic idx_clr;
    logic idx_inc;
    logic rd_idx;     // read slot table at scan index
    logic expire;     // clear valid[idx], park it; flush earlier parked one
    logic scan_end;   // flush parked word as last, or tick-done; advance wheel
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_e  op;
    logic id_oob;
    logic id_valid;
    logic idx_valid;
    logic idx_last;
    logic scan_hit;
    logic pend_valid;
    logic out_free;
  } sts_t;

endpackage

@@ sv/itw_ctrl.sv @@
`timescale 1ns / 1ps

module itw_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  itw_pkg::sts_t   sts_i,
  output itw_pkg::cmd_t   cmd_o
);

  itw_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= itw_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      itw_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = itw_pkg::ST_DECODE;
      end
      itw_pkg::ST_DECODE: begin
        case (sts_i.op)
          itw_pkg::OP_TOUCH:
            state_d = sts_i.id_oob ? itw_pkg::ST_NOT_FOUND : itw_pkg::ST_TOUCH;
          itw_pkg::OP_REMOVE:
            state_d = (sts_i.id_oob || !sts_i.id_valid) ? itw_pkg::ST_NOT_FOUND
                                                        : itw_pkg::ST_RM_RD;
          itw_pkg::OP_TICK: state_d = itw_pkg::ST_SCAN_RD;
          default:          state_d = itw_pkg::ST_IDLE;
        endcase
      end
      itw_pkg::ST_TOUCH, itw_pkg::ST_NOT_FOUND, itw_pkg::ST_RM_RES: begin
        if (sts_i.out_free) state_d = itw_pkg::ST_IDLE;
      end
      itw_pkg::ST_RM_RD: state_d = itw_pkg::ST_RM_RES;
      itw_pkg::ST_SCAN_RD: begin
        if (sts_i.idx_valid)     state_d = itw_pkg::ST_SCAN_CHK;
        else if (sts_i.idx_last) state_d = itw_pkg::ST_SCAN_END;
      end
      itw_pkg::ST_SCAN_CHK: begin
        if (!sts_i.scan_hit || !sts_i.pend_valid || sts_i.out_free) begin
          state_d = sts_i.idx_last ? itw_pkg::ST_SCAN_END : itw_pkg::ST_SCAN_RD;
        end
      end
      itw_pkg::ST_SCAN_END: begin
        if (sts_i.out_free) state_d = itw_pkg::ST_IDLE;
      end
      default: state_d = itw_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      itw_pkg::ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.latch_in = in_valid_i;
      end
      itw_pkg::ST_DECODE: begin
        cmd_o.idx_clr = (sts_i.op == itw_pkg::OP_TICK);
      end
      itw_pkg::ST_TOUCH:     cmd_o.touch     = sts_i.out_free;
      itw_pkg::ST_NOT_FOUND: cmd_o.not_found = sts_i.out_free;
      itw_pkg::ST_RM_RD:     cmd_o.rd_id     = 1'b1;
      itw_pkg::ST_RM_RES:    cmd_o.remove    = sts_i.out_free;
      itw_pkg::ST_SCAN_RD: begin
        cmd_o.rd_idx  = sts_i.idx_valid;
        cmd_o.idx_inc = !sts_i.idx_valid && !sts_i.idx_last;
      end
      itw_pkg::ST_SCAN_CHK: begin
        if (!sts_i.scan_hit) begin
          cmd_o.idx_inc = !sts_i.idx_last;
        end else if (!sts_i.pend_valid || sts_i.out_free) begin
          cmd_o.expire  = 1'b1;
          cmd_o.idx_inc = !sts_i.idx_last;
        end
      end
      itw_pkg::ST_SCAN_END: cmd_o.scan_end = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

@@ sv/itw_dp.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module itw_dp #(
  parameter int unsigned TIMEOUT  = itw_pkg::TIMEOUT_DEF,
  parameter int unsigned MAX_CONN = itw_pkg::MAX_CONN_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  itw_pkg::cmd_t                     cmd_i,
  output itw_pkg::sts_t                     sts_o,
  input  logic [itw_pkg::OP_W-1:0]          in_op_i,
  input  logic [itw_pkg::CONN_W-1:0]        in_conn_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [itw_pkg::CONN_W-1:0]        out_conn_o,
  output logic [itw_pkg::EV_W-1:0]          out_event_o,
  output logic [itw_pkg::SLOT_OUT_W-1:0]    out_slot_o,
  output logic                              out_last_o
);

  localparam int unsigned IdxW  = $clog2(MAX_CONN);
  localparam int unsigned SlotW = $clog2(TIMEOUT + 1);

  // latched word
  itw_pkg::op_e               op_q;
  logic [itw_pkg::CONN_W-1:0] id_q;

  // wheel state
  logic [MAX_CONN-1:0] valid_q;
  logic [SlotW-1:0]    slot_mem [MAX_CONN];
  logic [SlotW-1:0]    rd_data_q;
  logic [SlotW-1:0]    cur_q;

  // scan state
  logic [IdxW-1:0] idx_q;
  logic [IdxW-1:0] pend_idx_q;
  logic            pend_valid_q;

  logic [IdxW-1:0]  id_idx;
  logic             id_oob;
  logic             id_valid;
  logic [SlotW-1:0] touch_slot;
  logic [IdxW-1:0]  rd_addr;
  logic             push;
  logic [itw_pkg::CONN_W-1:0]     push_conn;
  itw_pkg::event_e                push_event;
  logic [SlotW-1:0]               push_slot;
  logic                           push_last;
  logic [SlotW+itw_pkg::SLOT_OUT_W-1:0] slot_ext;

  assign id_idx     = id_q[IdxW-1:0];
  assign id_oob     = ({1'b0, id_q} >= (itw_pkg::CONN_W + 1)'(MAX_CONN));
  assign id_valid   = !id_oob && valid_q[id_idx];
  assign touch_slot = (cur_q == '0) ? SlotW'(TIMEOUT) : cur_q - SlotW'(1);
  assign rd_addr    = cmd_i.rd_id ? id_idx : idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      op_q <= itw_pkg::op_e'(in_op_i);
      id_q <= in_conn_i;
    end
  end

  // slot table: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.touch) slot_mem[id_idx] <= touch_slot;
    if (cmd_i.rd_id || cmd_i.rd_idx) rd_data_q <= slot_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      cur_q        <= '0;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      if (cmd_i.touch)  valid_q[id_idx] <= 1'b1;
      if (cmd_i.remove) valid_q[id_idx] <= 1'b0;
      if (cmd_i.expire) valid_q[idx_q]  <= 1'b0;
      if (cmd_i.idx_clr)      idx_q <= '0;
      else if (cmd_i.idx_inc) idx_q <= idx_q + IdxW'(1);
      if (cmd_i.idx_clr || cmd_i.scan_end) pend_valid_q <= 1'b0;
      else if (cmd_i.expire)               pend_valid_q <= 1'b1;
      if (cmd_i.scan_end) cur_q <= (cur_q >= SlotW'(TIMEOUT)) ? '0 : cur_q + SlotW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.expire) pend_idx_q <= idx_q;
  end

  // result mux
  always_comb begin
    push       = 1'b0;
    push_conn  = id_q;
    push_event = itw_pkg::EV_NOT_FOUND;
    push_slot  = '0;
    push_last  = 1'b1;
    if (cmd_i.touch) begin
      push       = 1'b1;
      push_event = id_valid ? itw_pkg::EV_REARMED : itw_pkg::EV_ARMED;
      push_slot  = touch_slot;
    end else if (cmd_i.not_found) begin
      push = 1'b1;
    end else if (cmd_i.remove) begin
      push       = 1'b1;
      push_event = itw_pkg::EV_REMOVED;
      push_slot  = rd_data_q;
    end else if (cmd_i.expire) begin
      // a later hit proves the parked one is not the last
      push       = pend_valid_q;
      push_conn  = itw_pkg::CONN_W'(pend_idx_q);
      push_event = itw_pkg::EV_EXPIRED;
      push_slot  = cur_q;
      push_last  = 1'b0;
    end else if (cmd_i.scan_end) begin
      push       = 1'b1;
      push_conn  = pend_valid_q ? itw_pkg::CONN_W'(pend_idx_q) : '0;
      push_event = pend_valid_q ? itw_pkg::EV_EXPIRED : itw_pkg::EV_TICK_DONE;
      push_slot  = cur_q;
    end
  end

  assign slot_ext = {{itw_pkg::SLOT_OUT_W{1'b0}}, push_slot};

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (push) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_conn_o  <= push_conn;
      out_event_o <= push_event;
      out_slot_o  <= slot_ext[itw_pkg::SLOT_OUT_W-1:0];
      out_last_o  <= push_last;
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.op         = op_q;
    sts_o.id_oob     = id_oob;
    sts_o.id_valid   = id_valid;
    sts_o.idx_valid  = valid_q[idx_q];
    sts_o.idx_last   = (idx_q == IdxW'(MAX_CONN - 1));
    sts_o.scan_hit   = valid_q[idx_q] && (rd_data_q == cur_q);
    sts_o.pend_valid = pend_valid_q;
    sts_o.out_free   = !out_valid_o || out_ready_i;
  end

  `ASSERT_NEVER(a_push_overrun, clk_i, rst_ni, push && out_valid_o && !out_ready_i, "result overwrites untaken word")
  `ASSERT_NEVER(a_cur_range, clk_i, rst_ni, cur_q > SlotW'(TIMEOUT), "wheel pointer past last slot")
  `ASSERT_IMPL(a_cur_moves, clk_i, rst_ni, cmd_i.scan_end |=> cur_q != $past(cur_q), "tick did not advance wheel")
  `ASSERT_IMPL(a_touch_sets, clk_i, rst_ni, cmd_i.touch |=> valid_q[$past(id_idx)], "touch left entry invalid")

endmodule

@@ sv/idle_timeout_timing_wheel.sv @@
`timescale 1ns / 1ps

// Idle-timeout timing wheel: TIMEOUT+1 slots and a current pointer; each
// connection index below MAX_CONN holds a valid bit and a slot number.
// A touch word parks the connection one slot behind current (armed new or
// rearmed), a remove word drops it (or reports not found), and a tick word
// expires every connection waiting in the current slot, one result word
// each in ascending index order, or a single tick-done word, then moves the
// pointer on. tlast marks the final result of each input word; opcode 3
// gives no result. One input word is handled at a time. A tick scans every
// index below MAX_CONN in ascending order, reading the slot table only at
// valid indices; a busy result side stalls any operation. Reset clears all
// valid bits at once.
module idle_timeout_timing_wheel #(
  parameter int unsigned TIMEOUT  = itw_pkg::TIMEOUT_DEF,   // 1..31
  parameter int unsigned MAX_CONN = itw_pkg::MAX_CONN_DEF   // 2..64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [5:0] conn_id, [7:6] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [5:0] conn_id_res, [10:6] slot, [15:11] zero
  output logic [2:0]  m_axis_tuser,   // [2:0] event_res
  output logic        m_axis_tlast
);

  itw_pkg::cmd_t cmd;
  itw_pkg::sts_t sts;

  logic [itw_pkg::CONN_W-1:0]     out_conn;
  logic [itw_pkg::SLOT_OUT_W-1:0] out_slot;

  itw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  itw_dp #(
    .TIMEOUT  (TIMEOUT),
    .MAX_CONN (MAX_CONN)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_op_i     (s_axis_tuser),
    .in_conn_i   (s_axis_tdata[itw_pkg::CONN_W-1:0]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_conn_o  (out_conn),
    .out_event_o (m_axis_tuser),
    .out_slot_o  (out_slot),
    .out_last_o  (m_axis_tlast)
  );

  // pack result word, zero fill to 16 bits
  assign m_axis_tdata = {5'b0, out_slot, out_conn};

endmodule
